>>> design/circle_octant_rasterizer_assert.svh
// Assertion macros shared by the circle rasterizer RTL.
`ifndef CIRCLE_OCTANT_RASTERIZER_ASSERT_SVH
`define CIRCLE_OCTANT_RASTERIZER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define COR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define COR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/cor_pkg.sv
// Shared constants, mirror tables and types of the circle rasterizer.
`timescale 1ns / 1ps
package cor_pkg;

    localparam int COORD_BITS_DEF  = 11;
    localparam int RADIUS_BITS_DEF = 10;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Decision update constants
    localparam int DEC_INIT     = 3;
    localparam int DEC_STEP_NEG = 6;
    localparam int DEC_STEP_POS = 10;

    // Eight mirrored points per octant position
    localparam int NUM_MIRROR = 8;
    localparam int IDX_BITS   = $clog2(NUM_MIRROR);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_MIRROR - 1);

    // Point k: (x,y) (y,x) (-x,y) (y,-x) (-x,-y) (-y,-x) (x,-y) (-y,x)
    // bit k of SWAP: column offset uses y and row offset uses x
    localparam logic [NUM_MIRROR-1:0] MIR_SWAP   = 8'b1010_1010;
    localparam logic [NUM_MIRROR-1:0] MIR_NEG_DX = 8'b1011_0100;
    localparam logic [NUM_MIRROR-1:0] MIR_NEG_DY = 8'b0111_1000;

    // Status of the point serializer toward the top level
    typedef struct packed {
        logic busy;     // a descriptor is being sent out
        logic free;     // a new descriptor may load at this edge
    } t_emit_stat;

endpackage

>>> design/cor_step.sv
// Next walk state and emit descriptor for one start or step request.
`timescale 1ns / 1ps
module cor_step
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                   i_req_type,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic [RADIUS_BITS-1:0] i_x,
    input  logic [RADIUS_BITS-1:0] i_y,
    input  logic [RADIUS_BITS+2:0] i_dec,
    input  logic [COORD_BITS-1:0]  i_cx,
    input  logic [COORD_BITS-1:0]  i_cy,
    input  logic                   i_walking,
    output logic [RADIUS_BITS-1:0] o_x,
    output logic [RADIUS_BITS-1:0] o_y,
    output logic [RADIUS_BITS+2:0] o_dec,
    output logic [COORD_BITS-1:0]  o_cx,
    output logic [COORD_BITS-1:0]  o_cy,
    output logic                   o_walking,
    output logic                   o_done
);

    localparam int DEC_BITS = RADIUS_BITS + 3;

    logic                   w_neg;
    logic [DEC_BITS-1:0]    w_x4;
    logic [DEC_BITS-1:0]    w_y4;
    logic [DEC_BITS-1:0]    w_dec_step;
    logic [DEC_BITS-1:0]    w_dec_init;
    logic [RADIUS_BITS:0]   w_xn;
    logic [RADIUS_BITS:0]   w_yn;
    logic                   w_end;

    // Decision update from the old position
    assign w_neg      = i_dec[DEC_BITS-1];
    assign w_x4       = {1'b0, i_x, 2'b00};
    assign w_y4       = {1'b0, i_y, 2'b00};
    assign w_dec_step = w_neg ? (i_dec + w_x4 + DEC_BITS'(DEC_STEP_NEG))
                              : (i_dec + w_x4 - w_y4 + DEC_BITS'(DEC_STEP_POS));
    assign w_dec_init = DEC_BITS'(DEC_INIT) - {2'b00, i_radius, 1'b0};

    // Advance x, drop y on a non-negative decision, end once x passes y or y would drop below zero
    assign w_xn  = {1'b0, i_x} + (RADIUS_BITS+1)'(1);
    assign w_yn  = w_neg ? {1'b0, i_y} : ({1'b0, i_y} - (RADIUS_BITS+1)'(1));
    assign w_end = (!w_neg && (i_y == '0)) || (w_xn > w_yn);

    always_comb begin
        o_x       = i_x;
        o_y       = i_y;
        o_dec     = i_dec;
        o_cx      = i_cx;
        o_cy      = i_cy;
        o_walking = i_walking;
        o_done    = 1'b0;
        if (i_req_type == REQ_START) begin
            o_x       = '0;
            o_y       = i_radius;
            o_dec     = w_dec_init;
            o_cx      = i_center_x;
            o_cy      = i_center_y;
            o_walking = 1'b1;
        end else if (!i_walking || w_end) begin
            o_walking = 1'b0;
            o_done    = 1'b1;
        end else begin
            o_x   = w_xn[RADIUS_BITS-1:0];
            o_y   = w_yn[RADIUS_BITS-1:0];
            o_dec = w_dec_step;
        end
    end

endmodule

>>> design/cor_emit.sv
// Serializer that sends the eight mirrored points or the done result.
`timescale 1ns / 1ps
module cor_emit
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    input  logic [RADIUS_BITS-1:0]        i_x,
    input  logic [RADIUS_BITS-1:0]        i_y,
    input  logic                          i_done,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic signed [COORD_BITS+1:0]  o_pixel_x,
    output logic signed [COORD_BITS+1:0]  o_pixel_y,
    output logic                          o_pixel_valid,
    output logic                          o_circle_done,
    output logic                          o_last_of_item,
    output t_emit_stat                    o_stat
);

    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int WIDE     = (PIX_BITS > RADIUS_BITS) ? PIX_BITS : RADIUS_BITS + 1;

    logic                   r_busy;
    logic [IDX_BITS-1:0]    r_idx;
    logic [COORD_BITS-1:0]  r_cx;
    logic [COORD_BITS-1:0]  r_cy;
    logic [RADIUS_BITS-1:0] r_x;
    logic [RADIUS_BITS-1:0] r_y;
    logic                   r_done;

    logic                   w_last;
    logic                   w_fire;
    logic [RADIUS_BITS-1:0] w_off_x;
    logic [RADIUS_BITS-1:0] w_off_y;
    logic [WIDE-1:0]        w_sum_x;
    logic [WIDE-1:0]        w_sum_y;

    assign w_last = r_done || (r_idx == LAST_IDX);
    assign w_fire = r_busy && i_ready;

    // Hold the descriptor and count the mirrored points
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_fire && w_last) begin
            r_busy <= 1'b0;
        end else if (w_fire) begin
            r_idx  <= r_idx + IDX_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx   <= i_cx;
            r_cy   <= i_cy;
            r_x    <= i_x;
            r_y    <= i_y;
            r_done <= i_done;
        end
    end

    // Mirror the octant point and add the center
    assign w_off_x = MIR_SWAP[r_idx] ? r_y : r_x;
    assign w_off_y = MIR_SWAP[r_idx] ? r_x : r_y;
    assign w_sum_x = MIR_NEG_DX[r_idx] ? (WIDE'(r_cx) - WIDE'(w_off_x))
                                       : (WIDE'(r_cx) + WIDE'(w_off_x));
    assign w_sum_y = MIR_NEG_DY[r_idx] ? (WIDE'(r_cy) - WIDE'(w_off_y))
                                       : (WIDE'(r_cy) + WIDE'(w_off_y));

    assign o_valid        = r_busy;
    assign o_pixel_x      = r_done ? '0 : signed'(w_sum_x[PIX_BITS-1:0]);
    assign o_pixel_y      = r_done ? '0 : signed'(w_sum_y[PIX_BITS-1:0]);
    assign o_pixel_valid  = !r_done;
    assign o_circle_done  = r_done;
    assign o_last_of_item = w_last;

    assign o_stat.busy = r_busy;
    assign o_stat.free = !r_busy || (i_ready && w_last);

endmodule

>>> design/circle_octant_rasterizer.sv
// Top level of the midpoint circle rasterizer.
//
// A start transaction (req_type 0) latches center and radius and yields the eight
// mirrored points of (0, radius); each step transaction (req_type 1) advances the
// octant walk and yields eight more points, or one done result once x passes y or
// when no circle is active. Points leave one per cycle on the result channel when
// results are taken at once; the single-point result port sets that rate. The walk
// state updates in the cycle an item is accepted, and the next item is accepted in
// the same cycle that the last result of the previous one is taken, so items follow
// without a gap.
`timescale 1ns / 1ps
`include "circle_octant_rasterizer_assert.svh"
module circle_octant_rasterizer
    import cor_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [RADIUS_BITS-1:0]        i_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_BITS+1:0]  o_pixel_x,
    output logic signed [COORD_BITS+1:0]  o_pixel_y,
    output logic                          o_pixel_valid,
    output logic                          o_circle_done,
    output logic                          o_last_of_item
);

    localparam int DEC_BITS = RADIUS_BITS + 3;

    logic [RADIUS_BITS-1:0] r_x;
    logic [RADIUS_BITS-1:0] r_y;
    logic [DEC_BITS-1:0]    r_dec;
    logic [COORD_BITS-1:0]  r_cx;
    logic [COORD_BITS-1:0]  r_cy;
    logic                   r_walking;

    logic [RADIUS_BITS-1:0] n_x;
    logic [RADIUS_BITS-1:0] n_y;
    logic [DEC_BITS-1:0]    n_dec;
    logic [COORD_BITS-1:0]  n_cx;
    logic [COORD_BITS-1:0]  n_cy;
    logic                   n_walking;
    logic                   w_done;
    logic                   w_accept;
    t_emit_stat             w_stat;

    assign o_ready  = w_stat.free;
    assign w_accept = i_valid && o_ready;

    cor_step #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_step (
        .i_req_type (i_req_type),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_x        (r_x),
        .i_y        (r_y),
        .i_dec      (r_dec),
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_walking  (r_walking),
        .o_x        (n_x),
        .o_y        (n_y),
        .o_dec      (n_dec),
        .o_cx       (n_cx),
        .o_cy       (n_cy),
        .o_walking  (n_walking),
        .o_done     (w_done)
    );

    // Commit the walk state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_dec     <= '0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_walking <= 1'b0;
        end else if (w_accept) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_dec     <= n_dec;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_walking <= n_walking;
        end
    end

    cor_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_cx           (n_cx),
        .i_cy           (n_cy),
        .i_x            (n_x),
        .i_y            (n_y),
        .i_done         (w_done),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_valid  (o_pixel_valid),
        .o_circle_done  (o_circle_done),
        .o_last_of_item (o_last_of_item),
        .o_stat         (w_stat)
    );

    // Done results carry no point and close their transaction
    `COR_ASSERT(a_done_alone, (o_valid && o_circle_done) |-> (!o_pixel_valid && o_last_of_item), "done result carries a point")
    // No new transaction while a point other than the last is pending
    `COR_ASSERT(a_no_overlap, (w_stat.busy && !o_last_of_item) |-> !o_ready, "input taken mid burst")
    // A start always leaves a walk active
    `COR_ASSERT(a_start_walks, (w_accept && (i_req_type == REQ_START)) |=> r_walking, "start did not activate walk")
    // Reset empties the result channel
    `COR_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule
